// ----- sv/assert_macros.svh -----
// Assertion macros shared by the shape collision test RTL.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define SCT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("shape collision test assertion failed");

// Checks that an antecedent implies a consequent in the same cycle.
`define SCT_ASSERT_IMP(label, ante, cons) \
  `SCT_ASSERT(label, (ante) |-> (cons))

`endif

// ----- sv/sct_pkg.sv -----
// Package for the shape collision test: test kind codes.
// Depends on nothing; used by shape_collision_test.
package sct_pkg;

  typedef enum logic [2:0] {
    CMD_POINT_POINT   = 3'd0,
    CMD_POINT_BOX     = 3'd1,
    CMD_POINT_CIRCLE  = 3'd2,
    CMD_BOX_BOX       = 3'd3,
    CMD_CIRCLE_CIRCLE = 3'd4,
    CMD_CIRCLE_BOX    = 3'd5
  } cmd_t;

endpackage

// ----- sv/shape_collision_test.sv -----
// Top level of the shape collision test: a five-stage pipeline of compares and squares.
// Depends on sct_pkg and assert_macros.svh.
//
//   channel   ports                                  handshake
//   input     in_cmd, in_a_*, in_b_*                 start high, busy low
//   result    out_hit                                out_valid strobe, one cycle
//
// One transaction enters every cycle; busy is always low.
// The result strobe is the last of the valid bits v1_r to v5_r, one per stage:
// differences, compares and centre offsets, clamped residual, squares, and the
// final sum and compare.
// Synchronous reset clears the valid bits only; the result side cannot stall.
`include "assert_macros.svh"

module shape_collision_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_cmd,
  input  logic signed [COORD_BITS-1:0] in_a_x,
  input  logic signed [COORD_BITS-1:0] in_a_y,
  input  logic [COORD_BITS-2:0]        in_a_w,
  input  logic [COORD_BITS-2:0]        in_a_h,
  input  logic signed [COORD_BITS-1:0] in_b_x,
  input  logic signed [COORD_BITS-1:0] in_b_y,
  input  logic [COORD_BITS-2:0]        in_b_w,
  input  logic [COORD_BITS-2:0]        in_b_h,
  output logic                         out_valid,
  output logic                         out_hit
);

  localparam int W  = COORD_BITS + 2;
  localparam int SW = COORD_BITS - 1;

  logic accept;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // Stage 1 registers.
  sct_pkg::cmd_t        cmd1_r;
  logic signed [W-1:0]  dx1_r, dy1_r;
  logic [SW-1:0]        aw1_r, ah1_r, bw1_r, bh1_r;
  logic [COORD_BITS-1:0] rsum1_r;
  logic signed [W-1:0]  dx1_nxt, dy1_nxt;
  logic [COORD_BITS-1:0] rsum1_nxt;

  // Stage 2 registers.
  sct_pkg::cmd_t        cmd2_r;
  logic signed [W-1:0]  dx2_r, dy2_r, d5x2_r, d5y2_r;
  logic signed [W-1:0]  hw2_r, hh2_r;
  logic [COORD_BITS-1:0] rad2_r;
  logic                 flag2_r;
  logic signed [W-1:0]  d5x2_nxt, d5y2_nxt, hw2_nxt, hh2_nxt;
  logic [COORD_BITS-1:0] rad2_nxt;
  logic                 flag2_nxt;
  logic signed [W-1:0]  aw1_e, ah1_e, bw1_e, bh1_e;
  logic                 pp_hit, pbox_hit, bbox_hit;

  // Stage 3 registers.
  logic signed [W-1:0]  ex3_r, ey3_r;
  logic [COORD_BITS-1:0] rad3_r;
  logic                 flag3_r, dist3_r;
  logic signed [W-1:0]  ex3_nxt, ey3_nxt;
  logic                 dist3_nxt;

  // Stage 4 registers.
  logic signed [2*W-1:0] sqx4_r, sqy4_r;
  logic [2*COORD_BITS-1:0] sqr4_r;
  logic                 flag4_r, dist4_r, rzero4_r;
  logic signed [2*W-1:0] sqx4_nxt, sqy4_nxt;
  logic [2*COORD_BITS-1:0] sqr4_nxt;

  // Stage 5.
  logic [2*W:0]         sum5;
  logic                 hit5_nxt, hit5_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign dx1_nxt   = W'(in_a_x) - W'(in_b_x);
  assign dy1_nxt   = W'(in_a_y) - W'(in_b_y);
  assign rsum1_nxt = COORD_BITS'(in_a_w) + COORD_BITS'(in_b_w);

  assign aw1_e = $signed(W'(aw1_r));
  assign ah1_e = $signed(W'(ah1_r));
  assign bw1_e = $signed(W'(bw1_r));
  assign bh1_e = $signed(W'(bh1_r));

  always_comb begin
    pp_hit   = (dx1_r == '0) && (dy1_r == '0);
    pbox_hit = (dx1_r > 0) && (dx1_r < bw1_e) && (dy1_r > 0) && (dy1_r < bh1_e);
    bbox_hit = (dx1_r > -aw1_e) && (dx1_r < bw1_e) && (dy1_r > -ah1_e) && (dy1_r < bh1_e);
    hw2_nxt  = $signed(W'(bw1_r >> 1));
    hh2_nxt  = $signed(W'(bh1_r >> 1));
    d5x2_nxt = dx1_r - hw2_nxt;
    d5y2_nxt = dy1_r - hh2_nxt;
    flag2_nxt = 1'b0;
    rad2_nxt  = '0;
    case (cmd1_r)
      sct_pkg::CMD_POINT_POINT:   flag2_nxt = pp_hit;
      sct_pkg::CMD_POINT_BOX:     flag2_nxt = pbox_hit;
      sct_pkg::CMD_BOX_BOX:       flag2_nxt = bbox_hit;
      sct_pkg::CMD_POINT_CIRCLE:  rad2_nxt  = COORD_BITS'(bw1_r);
      sct_pkg::CMD_CIRCLE_CIRCLE: rad2_nxt  = rsum1_r;
      sct_pkg::CMD_CIRCLE_BOX:    rad2_nxt  = COORD_BITS'(aw1_r);
      default: begin
        flag2_nxt = 1'b0;
        rad2_nxt  = '0;
      end
    endcase
  end

  always_comb begin
    ex3_nxt   = dx2_r;
    ey3_nxt   = dy2_r;
    dist3_nxt = 1'b0;
    case (cmd2_r)
      sct_pkg::CMD_POINT_CIRCLE,
      sct_pkg::CMD_CIRCLE_CIRCLE: dist3_nxt = 1'b1;
      sct_pkg::CMD_CIRCLE_BOX: begin
        dist3_nxt = 1'b1;
        if (d5x2_r > hw2_r) begin
          ex3_nxt = d5x2_r - hw2_r;
        end else if (d5x2_r < -hw2_r) begin
          ex3_nxt = d5x2_r + hw2_r;
        end else begin
          ex3_nxt = '0;
        end
        if (d5y2_r > hh2_r) begin
          ey3_nxt = d5y2_r - hh2_r;
        end else if (d5y2_r < -hh2_r) begin
          ey3_nxt = d5y2_r + hh2_r;
        end else begin
          ey3_nxt = '0;
        end
      end
      default: dist3_nxt = 1'b0;
    endcase
  end

  assign sqx4_nxt = ex3_r * ex3_r;
  assign sqy4_nxt = ey3_r * ey3_r;
  assign sqr4_nxt = rad3_r * rad3_r;

  assign sum5     = (2*W+1)'($unsigned(sqx4_r)) + (2*W+1)'($unsigned(sqy4_r));
  assign hit5_nxt = dist4_r ? (sum5 < (2*W+1)'(sqr4_r)) : flag4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd1_r  <= sct_pkg::cmd_t'(in_cmd);
    dx1_r   <= dx1_nxt;
    dy1_r   <= dy1_nxt;
    aw1_r   <= in_a_w;
    ah1_r   <= in_a_h;
    bw1_r   <= in_b_w;
    bh1_r   <= in_b_h;
    rsum1_r <= rsum1_nxt;

    cmd2_r  <= cmd1_r;
    dx2_r   <= dx1_r;
    dy2_r   <= dy1_r;
    d5x2_r  <= d5x2_nxt;
    d5y2_r  <= d5y2_nxt;
    hw2_r   <= hw2_nxt;
    hh2_r   <= hh2_nxt;
    rad2_r  <= rad2_nxt;
    flag2_r <= flag2_nxt;

    ex3_r   <= ex3_nxt;
    ey3_r   <= ey3_nxt;
    rad3_r  <= rad2_r;
    flag3_r <= flag2_r;
    dist3_r <= dist3_nxt;

    sqx4_r   <= sqx4_nxt;
    sqy4_r   <= sqy4_nxt;
    sqr4_r   <= sqr4_nxt;
    flag4_r  <= flag3_r;
    dist4_r  <= dist3_r;
    rzero4_r <= (rad3_r == '0);

    hit5_r <= hit5_nxt;
  end

  assign out_valid = v5_r;
  assign out_hit   = v5_r && hit5_r;

  `SCT_ASSERT_IMP(a_latency, out_valid, $past(start && !busy, 5))
  `SCT_ASSERT_IMP(a_hit_strobed, out_hit, out_valid)
  `SCT_ASSERT(a_zero_radius, (v4_r && dist4_r && rzero4_r) |=> !out_hit)

endmodule
